// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the box containment test.
// Depends on a clock clk_i and an active-low reset rst_ni in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== hw/rtl/pibpt_pkg.sv =====
// Package for the box containment test: widths, vertex type, face table.
// No dependencies.
package pibpt_pkg;

  localparam int CoordBits = 16;
  localparam int IdxW      = 3;
  localparam int NumVtx    = 8;
  localparam int NumFaces  = 6;
  localparam int VtxW      = 3 * CoordBits;
  localparam int InTdataW  = 8 * ((IdxW + VtxW + 7) / 8);
  localparam int OutTdataW = 8;

  // Datapath widths: edge differences, doubled offsets, normals, products, sums.
  localparam int DiffW = CoordBits + 1;
  localparam int DblW  = CoordBits + 2;
  localparam int NrmW  = 2 * DiffW + 1;
  localparam int ProdW = NrmW + DblW;
  localparam int AccW  = ProdW + 2;

  localparam logic [IdxW-1:0] CenterA = IdxW'(3);
  localparam logic [IdxW-1:0] CenterB = IdxW'(5);
  localparam logic [2:0]      LastFace = 3'(NumFaces - 1);

  typedef struct packed {
    logic signed [CoordBits-1:0] z;
    logic signed [CoordBits-1:0] y;
    logic signed [CoordBits-1:0] x;
  } vertex_t;

  function automatic logic signed [CoordBits-1:0] coord_of(vertex_t v, int k);
    logic signed [CoordBits-1:0] r;
    case (k)
      0:       r = v.x;
      1:       r = v.y;
      default: r = v.z;
    endcase
    return r;
  endfunction

  // Corner (a, b, c) of each face plane.
  function automatic logic [IdxW-1:0] face_vtx(logic [2:0] face, logic [1:0] corner);
    logic [IdxW-1:0] r;
    r = '0;
    case (face)
      3'd0: case (corner) 2'd0: r = 3'd0; 2'd1: r = 3'd1; default: r = 3'd2; endcase
      3'd1: case (corner) 2'd0: r = 3'd5; 2'd1: r = 3'd6; default: r = 3'd2; endcase
      3'd2: case (corner) 2'd0: r = 3'd4; 2'd1: r = 3'd0; default: r = 3'd3; endcase
      3'd3: case (corner) 2'd0: r = 3'd7; 2'd1: r = 3'd3; default: r = 3'd2; endcase
      3'd4: case (corner) 2'd0: r = 3'd5; 2'd1: r = 3'd1; default: r = 3'd0; endcase
      3'd5: case (corner) 2'd0: r = 3'd7; 2'd1: r = 3'd6; default: r = 3'd5; endcase
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/point_in_box_plane_test.sv =====
// Box containment test: eight corner vertices in a small synchronous memory,
// six face planes built and checked with one shared multiplier.
// Depends on pibpt_pkg and assert_macros.svh.
//
// Sequence: a test item fetches the two center corners, then for each face
//   reads its vertices, builds the normal and forms the two dot products on
//   the single multiplier; the result waits while the output is not free.
// Throughput: one load item per cycle while idle; no item is taken during a test.
// Reset: clears control, event enable and the vertex valid bits (all corners
//   read as zero); the vertex memory itself is not cleared.
`include "assert_macros.svh"

module point_in_box_plane_test (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration: event_enable
  input  logic                               cfg_we_i,
  input  logic                               cfg_wdata_i,
  // Input items
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // tdata, low bit up: vertex_index[2:0], coord_x[15:0], coord_y[15:0], coord_z[15:0]
  input  logic [pibpt_pkg::InTdataW-1:0]     s_axis_tdata_i,
  // tuser: kind (0 load vertex, 1 test point)
  input  logic                               s_axis_tuser_i,
  // Result items
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // tdata, low bit up: inside_res, then zero fill
  output logic [pibpt_pkg::OutTdataW-1:0]    m_axis_tdata_o
);
  import pibpt_pkg::*;

  // Sequencer states.
  localparam logic [2:0] SIdle   = 3'd0;
  localparam logic [2:0] SCenter = 3'd1;
  localparam logic [2:0] SFetch  = 3'd2;
  localparam logic [2:0] SNormal = 3'd3;
  localparam logic [2:0] SDot    = 3'd4;
  localparam logic [2:0] SOut    = 3'd5;
  localparam logic [2:0] LastMul = 3'd6;

  logic [2:0] state_q;
  logic [2:0] step_q;   // step within the current phase
  logic [2:0] face_q;
  logic       event_en_q;
  logic       m_valid_q;
  logic       m_inside_q;

  // Vertex memory: one write port, one registered read port.
  vertex_t           mem_q [NumVtx];
  logic [NumVtx-1:0] vld_q;
  vertex_t           rd_q;
  logic              rd_vld_q;
  logic [IdxW-1:0]   rd_addr;
  vertex_t           rd_v;

  // Payload registers of the running test.
  logic signed [DiffW-1:0]     p2_q  [3];  // doubled point
  logic signed [DiffW-1:0]     cen_q [3];  // v3 + v5 (doubled center)
  logic signed [CoordBits-1:0] a_q   [3];
  logic signed [DiffW-1:0]     u_q   [3];
  logic signed [DiffW-1:0]     v_q   [3];
  logic signed [NrmW-1:0]      n_q   [3];
  logic signed [ProdW-1:0]     prod_q;
  logic signed [AccW-1:0]      acc_q;
  logic                        side_p_q;
  logic                        inside_q;

  logic signed [DblW-1:0]  dp_w [3];
  logic signed [DblW-1:0]  dc_w [3];
  logic signed [NrmW-1:0]  op_a;
  logic signed [DblW-1:0]  op_b;
  logic signed [ProdW-1:0] mul_w;
  logic signed [AccW-1:0]  acc_sum;

  logic            s_acc;
  logic            load_acc;
  logic            test_go;
  logic            out_free;
  logic [IdxW-1:0] in_idx;
  vertex_t         in_vtx;

  // Input decode: tdata packs index, then x, y, z.
  assign in_idx   = s_axis_tdata_i[IdxW-1:0];
  assign in_vtx   = s_axis_tdata_i[IdxW +: VtxW];

  // Take items only between tests; a held result does not block new items.
  assign s_axis_tready_o = (state_q == SIdle);
  assign s_acc           = s_axis_tvalid_i & s_axis_tready_o;
  assign load_acc        = s_acc & ~s_axis_tuser_i;
  assign test_go         = s_acc & s_axis_tuser_i & event_en_q;
  assign out_free        = ~m_valid_q | m_axis_tready_i;

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = OutTdataW'(m_inside_q);

  // Read address: center corners first, then the face triple.
  always_comb begin
    case (state_q)
      SCenter: rd_addr = (step_q == 3'd0) ? CenterA : CenterB;
      SFetch:  rd_addr = face_vtx(face_q, step_q[1:0]);
      default: rd_addr = CenterA;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load_acc) begin
      mem_q[in_idx] <= in_vtx;
    end
    rd_q <= mem_q[rd_addr];
  end

  // A corner never written reads as zero.
  assign rd_v = rd_vld_q ? rd_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (load_acc) begin
        vld_q[in_idx] <= 1'b1;
      end
      rd_vld_q <= vld_q[rd_addr];
    end
  end

  // Offsets of point and center from corner a, both doubled.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dp_w[k] = DblW'(p2_q[k]) - DblW'($signed({a_q[k], 1'b0}));
      dc_w[k] = DblW'(cen_q[k]) - DblW'($signed({a_q[k], 1'b0}));
    end
  end

  // Shared multiplier operands.
  always_comb begin
    op_a = '0;
    op_b = '0;
    if (state_q == SNormal) begin
      case (step_q)
        3'd0: begin op_a = NrmW'(u_q[1]); op_b = DblW'(v_q[2]); end
        3'd1: begin op_a = NrmW'(u_q[2]); op_b = DblW'(v_q[1]); end
        3'd2: begin op_a = NrmW'(u_q[2]); op_b = DblW'(v_q[0]); end
        3'd3: begin op_a = NrmW'(u_q[0]); op_b = DblW'(v_q[2]); end
        3'd4: begin op_a = NrmW'(u_q[0]); op_b = DblW'(v_q[1]); end
        3'd5: begin op_a = NrmW'(u_q[1]); op_b = DblW'(v_q[0]); end
        default: ;
      endcase
    end else begin
      case (step_q)
        3'd0: begin op_a = n_q[0]; op_b = dp_w[0]; end
        3'd1: begin op_a = n_q[1]; op_b = dp_w[1]; end
        3'd2: begin op_a = n_q[2]; op_b = dp_w[2]; end
        3'd3: begin op_a = n_q[0]; op_b = dc_w[0]; end
        3'd4: begin op_a = n_q[1]; op_b = dc_w[1]; end
        3'd5: begin op_a = n_q[2]; op_b = dc_w[2]; end
        default: ;
      endcase
    end
  end

  assign mul_w   = op_a * op_b;
  assign acc_sum = acc_q + AccW'(prod_q);

  // Datapath: payload registers, no reset.
  always_ff @(posedge clk_i) begin
    prod_q <= mul_w;
    if (test_go) begin
      p2_q[0]  <= $signed({in_vtx.x, 1'b0});
      p2_q[1]  <= $signed({in_vtx.y, 1'b0});
      p2_q[2]  <= $signed({in_vtx.z, 1'b0});
      inside_q <= 1'b1;
    end
    case (state_q)
      SCenter: begin
        for (int k = 0; k < 3; k++) begin
          if (step_q == 3'd1) cen_q[k] <= DiffW'(coord_of(rd_v, k));
          if (step_q == 3'd2) cen_q[k] <= cen_q[k] + DiffW'(coord_of(rd_v, k));
        end
      end
      SFetch: begin
        for (int k = 0; k < 3; k++) begin
          if (step_q == 3'd1) a_q[k] <= coord_of(rd_v, k);
          if (step_q == 3'd2) u_q[k] <= DiffW'(coord_of(rd_v, k)) - DiffW'(a_q[k]);
          if (step_q == 3'd3) v_q[k] <= DiffW'(coord_of(rd_v, k)) - DiffW'(a_q[k]);
        end
      end
      SNormal: begin
        // Each product is taken from prod_q in the step after its operands.
        case (step_q)
          3'd1: n_q[0] <= NrmW'(prod_q);
          3'd2: n_q[0] <= n_q[0] - NrmW'(prod_q);
          3'd3: n_q[1] <= NrmW'(prod_q);
          3'd4: n_q[1] <= n_q[1] - NrmW'(prod_q);
          3'd5: n_q[2] <= NrmW'(prod_q);
          3'd6: n_q[2] <= n_q[2] - NrmW'(prod_q);
          default: ;
        endcase
      end
      SDot: begin
        case (step_q)
          3'd1: acc_q <= AccW'(prod_q);
          3'd2: acc_q <= acc_sum;
          3'd3: begin
            acc_q    <= acc_sum;
            side_p_q <= ~acc_sum[AccW-1];
          end
          3'd4: acc_q <= AccW'(prod_q);
          3'd5: acc_q <= acc_sum;
          3'd6: begin
            // Drop the point when it sits on the other side from the center.
            if (side_p_q != ~acc_sum[AccW-1]) inside_q <= 1'b0;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Sequencer, config register and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SIdle;
      step_q     <= '0;
      face_q     <= '0;
      event_en_q <= 1'b0;
      m_valid_q  <= 1'b0;
      m_inside_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        event_en_q <= cfg_wdata_i;
      end
      // The output step reloads the result register itself.
      if (m_valid_q && m_axis_tready_i && (state_q != SOut)) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        SIdle: begin
          if (test_go) begin
            state_q <= SCenter;
            step_q  <= '0;
          end
        end
        SCenter: begin
          if (step_q == 3'd2) begin
            state_q <= SFetch;
            step_q  <= '0;
            face_q  <= '0;
          end else begin
            step_q <= step_q + 3'd1;
          end
        end
        SFetch: begin
          if (step_q == 3'd3) begin
            state_q <= SNormal;
            step_q  <= '0;
          end else begin
            step_q <= step_q + 3'd1;
          end
        end
        SNormal: begin
          if (step_q == LastMul) begin
            state_q <= SDot;
            step_q  <= '0;
          end else begin
            step_q <= step_q + 3'd1;
          end
        end
        SDot: begin
          if (step_q != LastMul) begin
            step_q <= step_q + 3'd1;
          end else if (face_q == LastFace) begin
            state_q <= SOut;
            step_q  <= '0;
          end else begin
            state_q <= SFetch;
            step_q  <= '0;
            face_q  <= face_q + 3'd1;
          end
        end
        SOut: begin
          // Hold until the result register is free.
          if (out_free) begin
            m_valid_q  <= 1'b1;
            m_inside_q <= inside_q;
            state_q    <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  `ASSERT_CLK(a_test_starts, (s_acc && s_axis_tuser_i && event_en_q) |=> (state_q == SCenter), "enabled test did not start")
  `ASSERT_CLK(a_result_from_out, $rose(m_valid_q) |-> $past(state_q == SOut), "result raised outside output step")
  `ASSERT_NEVER(a_face_range, face_q > LastFace, "face counter out of range")
  `ASSERT_NEVER(a_step_range, step_q > LastMul, "step counter out of range")

endmodule

// ===== sim/tb_top.sv =====
// Self-checking bench for point_in_box_plane_test: loads box corners, streams
// test points and compares each inside flag with a bit-exact predictor.
// Depends on pibpt_pkg and the point_in_box_plane_test RTL only.
`timescale 1ns / 100ps

module tb_top;
  import pibpt_pkg::*;

  // Item kinds carried on tuser
  localparam bit KindLoad = 1'b0;
  localparam bit KindTest = 1'b1;

  // Margin after the last result before a register write or the final verdict;
  // covers the run time of a test item, so the block is idle by then.
  localparam int SettleCycles = 150;

  // Corner triple (a, b, c) of each face plane, face 0 first
  localparam logic [0:NumFaces-1][0:2][IdxW-1:0] FaceCorners = {
    3'd0, 3'd1, 3'd2,
    3'd5, 3'd6, 3'd2,
    3'd4, 3'd0, 3'd3,
    3'd7, 3'd3, 3'd2,
    3'd5, 3'd1, 3'd0,
    3'd7, 3'd6, 3'd5
  };

  // Which corners sit one edge step along x, y, z (bit i = corner i)
  localparam logic [NumVtx-1:0] StepX = 8'h66;
  localparam logic [NumVtx-1:0] StepY = 8'hCC;
  localparam logic [NumVtx-1:0] StepZ = 8'hF0;

  localparam int Half = 1000;   // half edge of the directed cube

  typedef logic signed [CoordBits-1:0] coord_t;

  typedef struct packed {
    bit              cfg_wr;        // write event_enable before this row
    bit              cfg_val;
    bit              kind;
    logic [IdxW-1:0] idx;
    coord_t          x;
    coord_t          y;
    coord_t          z;
    bit              typed;         // expected flag given below, not predicted
    bit              typed_inside;
  } stim_row_t;

  localparam int NumDirRows = 25;

  // Directed rows: zero box, extremes, a cube, a skewed box, a flat face,
  // and tests with events switched off.
  stim_row_t dir_rows [NumDirRows] = '{
    // events still off after reset: no result
    '{1'b0, 1'b0, KindTest, 3'd7, 0, 0, 0, 1'b0, 1'b0},
    // all corners zero: every plane degenerate, so always inside
    '{1'b1, 1'b1, KindTest, 3'd0, 0, 0, 0, 1'b1, 1'b1},
    '{1'b0, 1'b0, KindTest, 3'd5, 32767, -32768, 32767, 1'b1, 1'b1},
    '{1'b0, 1'b0, KindTest, 3'd2, -32768, 32767, -32768, 1'b1, 1'b1},
    // axis-aligned cube
    '{1'b0, 1'b0, KindLoad, 3'd0, -Half, -Half, -Half, 1'b0, 1'b0},
    '{1'b0, 1'b0, KindLoad, 3'd1,  Half, -Half, -Half, 1'b0, 1'b0},
    '{1'b0, 1'b0, KindLoad, 3'd2,  Half,  Half, -Half, 1'b0, 1'b0},
    '{1'b0, 1'b0, KindLoad, 3'd3, -Half,  Half, -Half, 1'b0, 1'b0},
    '{1'b0, 1'b0, KindLoad, 3'd4, -Half, -Half,  Half, 1'b0, 1'b0},
    '{1'b0, 1'b0, KindLoad, 3'd5,  Half, -Half,  Half, 1'b0, 1'b0},
    '{1'b0, 1'b0, KindLoad, 3'd6,  Half,  Half,  Half, 1'b0, 1'b0},
    '{1'b0, 1'b0, KindLoad, 3'd7, -Half,  Half,  Half, 1'b0, 1'b0},
    '{1'b0, 1'b0, KindTest, 3'd1, 0, 0, 0, 1'b0, 1'b0},
    '{1'b0, 1'b0, KindTest, 3'd6, Half, Half, Half, 1'b0, 1'b0},
    '{1'b0, 1'b0, KindTest, 3'd3, Half + 1, 0, 0, 1'b0, 1'b0},
    '{1'b0, 1'b0, KindTest, 3'd4, 32767, 32767, 32767, 1'b0, 1'b0},
    '{1'b0, 1'b0, KindTest, 3'd0, -32768, -32768, -32768, 1'b0, 1'b0},
    // move the two center corners to the extremes
    '{1'b0, 1'b0, KindLoad, 3'd3, -32768, 32767, -32768, 1'b0, 1'b0},
    '{1'b0, 1'b0, KindLoad, 3'd5, 32767, -32768, 32767, 1'b0, 1'b0},
    '{1'b0, 1'b0, KindTest, 3'd7, 1, -1, 1, 1'b0, 1'b0},
    '{1'b0, 1'b0, KindTest, 3'd2, -32768, 32767, -32768, 1'b0, 1'b0},
    // corner 1 on top of corner 0: two planes collapse to a zero normal
    '{1'b0, 1'b0, KindLoad, 3'd1, -Half, -Half, -Half, 1'b0, 1'b0},
    '{1'b0, 1'b0, KindTest, 3'd5, 0, -Half, 0, 1'b0, 1'b0},
    // events off again: no result
    '{1'b1, 1'b0, KindTest, 3'd4, 0, 0, 0, 1'b0, 1'b0},
    '{1'b0, 1'b0, KindLoad, 3'd6, -1, -1, -1, 1'b0, 1'b0}
  };

  // DUT ports, all inputs driven to known values from time zero
  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 cfg_we_i        = 1'b0;
  logic                 cfg_wdata_i     = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [InTdataW-1:0]  s_axis_tdata_i  = '0;
  logic                 s_axis_tuser_i  = 1'b0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata_o;

  // Predictor state: corner store and event enable, as the block holds them
  vertex_t box_corners [NumVtx] = '{default: '0};
  bit      events_on            = 1'b0;
  bit      inside_expected_q [$];

  int error_count    = 0;
  int src_gap_pct    = 0;
  int sink_stall_pct = 0;
  bit use_typed      = 1'b0;
  bit typed_inside   = 1'b0;

  // Current random box: base corner, edge vectors for the x, y and z steps, corner jitter
  int shape_base [3];
  int shape_edge [3][3];
  int shape_jitter;

  point_in_box_plane_test u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Inside test on doubled coordinates: the point must sit on the same side
  // of every face plane as the box center (v3 + v5) / 2. Zero distance counts
  // as the non-negative side, so a zero normal never rejects.
  function automatic bit point_inside_box(vertex_t p);
    vertex_t                 a, b, c;
    logic signed [DiffW-1:0] ux, uy, uz, vx, vy, vz;
    logic signed [NrmW-1:0]  nx, ny, nz;
    logic signed [DblW-1:0]  px, py, pz, cx, cy, cz;
    logic signed [AccW-1:0]  dist_p, dist_c;
    bit                      in_box;
    in_box = 1'b1;
    for (int f = 0; f < NumFaces; f++) begin
      a  = box_corners[FaceCorners[f][0]];
      b  = box_corners[FaceCorners[f][1]];
      c  = box_corners[FaceCorners[f][2]];
      ux = b.x - a.x;
      uy = b.y - a.y;
      uz = b.z - a.z;
      vx = c.x - a.x;
      vy = c.y - a.y;
      vz = c.z - a.z;
      nx = uy * vz - uz * vy;
      ny = uz * vx - ux * vz;
      nz = ux * vy - uy * vx;
      px = 2 * p.x - 2 * a.x;
      py = 2 * p.y - 2 * a.y;
      pz = 2 * p.z - 2 * a.z;
      cx = box_corners[CenterA].x + box_corners[CenterB].x - 2 * a.x;
      cy = box_corners[CenterA].y + box_corners[CenterB].y - 2 * a.y;
      cz = box_corners[CenterA].z + box_corners[CenterB].z - 2 * a.z;
      dist_p = nx * px + ny * py + nz * pz;
      dist_c = nx * cx + ny * cy + nz * cz;
      if (dist_p[AccW-1] != dist_c[AccW-1]) in_box = 1'b0;
    end
    return in_box;
  endfunction

  function automatic coord_t sat_coord(int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return coord_t'(v);
  endfunction

  // Coordinate k of corner i of the current random box, before jitter
  function automatic int corner_coord(int i, int k);
    return shape_base[k] + (StepX[i] ? shape_edge[0][k] : 0)
         + (StepY[i] ? shape_edge[1][k] : 0) + (StepZ[i] ? shape_edge[2][k] : 0);
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    error_count++;
  endtask

  // Drive one item from a falling edge, hold it until accepted, then update
  // the predictor. Returns in the time step of the accepting rising edge.
  task automatic send_item(bit kind, logic [IdxW-1:0] idx, coord_t x, coord_t y, coord_t z);
    vertex_t v;
    v.x = x;
    v.y = y;
    v.z = z;
    @(negedge clk_i);
    while ($urandom_range(99) < src_gap_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= InTdataW'({v, idx});
    s_axis_tuser_i  <= kind;
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (kind == KindLoad) begin
      box_corners[idx] = v;
    end else if (events_on) begin
      inside_expected_q.push_back(use_typed ? typed_inside : point_inside_box(v));
    end
  endtask

  // Drop valid and hold off until every expected result has come
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (inside_expected_q.size() != 0) @(negedge clk_i);
  endtask

  // Write event_enable only while the block is idle
  task automatic write_event_enable(bit en);
    drain_results();
    repeat (SettleCycles) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= en;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    events_on = en;
  endtask

  // Pick a random box: full-range axis aligned, tiny, or a skewed
  // parallelepiped of moderate size; a quarter get off-plane corners.
  task automatic make_shape();
    int style, lo, hi;
    style = $urandom_range(3);
    for (int k = 0; k < 3; k++) begin
      if (style == 0) begin
        lo = int'($urandom_range(65535)) - 32768;
        hi = int'($urandom_range(65535)) - 32768;
        if (hi < lo) begin
          shape_base[k] = hi;
          hi            = lo;
          lo            = shape_base[k];
        end
        shape_base[k] = lo;
        for (int j = 0; j < 3; j++) shape_edge[j][k] = (j == k) ? hi - lo : 0;
      end else if (style == 1) begin
        shape_base[k] = int'($urandom_range(64000)) - 32000;
        for (int j = 0; j < 3; j++) shape_edge[j][k] = int'($urandom_range(16)) - 8;
      end else begin
        shape_base[k] = int'($urandom_range(32000)) - 16000;
        for (int j = 0; j < 3; j++) shape_edge[j][k] = int'($urandom_range(10000)) - 5000;
      end
    end
    shape_jitter = ($urandom_range(3) == 0) ? 32 : 0;
  endtask

  // Random part: mostly a box load followed by probes around it, plus
  // partial loads, stray loads and stray tests anywhere in the field range.
  task automatic run_phase(bit en, int gap_pct, int stall_pct, int n_items, bit pause_often);
    int sent, pick, n_load, n_test, rot, jit;
    int w [3];
    coord_t q [3];
    write_event_enable(en);
    src_gap_pct    = gap_pct;
    sink_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        make_shape();
        // broken sequence now and then: only some corners replaced
        n_load = ($urandom_range(6) == 0) ? $urandom_range(1, 7) : NumVtx;
        rot    = $urandom_range(NumVtx - 1);
        for (int i = 0; i < n_load; i++) begin
          for (int k = 0; k < 3; k++) begin
            jit  = shape_jitter ? int'($urandom_range(2 * shape_jitter)) - shape_jitter : 0;
            q[k] = sat_coord(corner_coord((rot + i) % NumVtx, k) + jit);
          end
          send_item(KindLoad, IdxW'((rot + i) % NumVtx), q[0], q[1], q[2]);
        end
        n_test = $urandom_range(2, 10);
        for (int t = 0; t < n_test; t++) begin
          // probe in eighths of an edge: exact corners, inside, and a bit beyond
          for (int j = 0; j < 3; j++) begin
            w[j] = ($urandom_range(4) == 0) ? 8 * int'($urandom_range(1))
                                            : int'($urandom_range(12)) - 2;
          end
          for (int k = 0; k < 3; k++) begin
            q[k] = sat_coord(shape_base[k] + (w[0] * shape_edge[0][k]
                   + w[1] * shape_edge[1][k] + w[2] * shape_edge[2][k]) / 8);
          end
          send_item(KindTest, IdxW'($urandom_range(NumVtx - 1)), q[0], q[1], q[2]);
        end
        sent += n_load + n_test;
        if (pause_often && $urandom_range(3) == 0) drain_results();
      end else begin
        send_item(pick < 85 ? KindLoad : KindTest, IdxW'($urandom_range(NumVtx - 1)),
                  coord_t'($urandom()), coord_t'($urandom()), coord_t'($urandom()));
        sent++;
      end
    end
  endtask

  // Receiver: stall at random at each falling edge
  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Result checker: compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (inside_expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result, inside_res=%b", m_axis_tdata_o[0]));
      end else begin
        if (m_axis_tdata_o[0] !== inside_expected_q[0]) begin
          report_mismatch($sformatf("inside_res=%b, expected %b",
                                    m_axis_tdata_o[0], inside_expected_q[0]));
        end
        void'(inside_expected_q.pop_front());
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows, no idling
    for (int r = 0; r < NumDirRows; r++) begin
      if (dir_rows[r].cfg_wr) write_event_enable(dir_rows[r].cfg_val);
      use_typed    = dir_rows[r].typed;
      typed_inside = dir_rows[r].typed_inside;
      send_item(dir_rows[r].kind, dir_rows[r].idx, dir_rows[r].x, dir_rows[r].y,
                dir_rows[r].z);
    end
    use_typed = 1'b0;

    // Random phases: sender idles lightly with a slow receiver, events off,
    // then a slow sender with a quick receiver, then full rate with pauses.
    run_phase(1'b1, 30, 88, 640, 1'b0);
    run_phase(1'b0, 0, 0, 100, 1'b0);
    run_phase(1'b1, 88, 30, 640, 1'b0);
    run_phase(1'b1, 0, 0, 570, 1'b1);

    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: several times the slowest correct run
  initial begin
    #6000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
